/* hdl/wfs_pkg.sv */
`timescale 1ns / 1ps

package wfs_pkg;

    localparam int DIST_W   = 11;   // signed range reading, -1 = no echo
    localparam int DUTY_W   = 8;
    localparam int GAIN_W   = 8;
    localparam int LIMIT_W  = 10;
    localparam int ERR_W    = 8;    // stored error, saturated
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [1:0] {
        MODE_STEER = 2'd0,
        MODE_LEFT  = 2'd1,
        MODE_RIGHT = 2'd2
    } drive_mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_DUTY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LIMIT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED      = 3'd5;

    localparam logic [DUTY_W-1:0]  RST_CRUISE_DUTY     = 8'd250;
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN       = 8'd64;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN      = 8'd80;
    localparam logic [LIMIT_W-1:0] RST_FRONT_THRESHOLD = 10'd7;
    localparam logic [LIMIT_W-1:0] RST_SIDE_LIMIT      = 10'd60;
    localparam logic [DUTY_W-1:0]  RST_TURN_SPEED      = 8'd200;

endpackage

/* hdl/wfs_sensor_if.sv */
`timescale 1ns / 1ps

interface wfs_sensor_if import wfs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DIST_W-1:0] center_distance;
    logic signed [DIST_W-1:0] left_distance;
    logic signed [DIST_W-1:0] right_distance;

    modport source (output valid, center_distance, left_distance, right_distance,
                    input ready);
    modport sink   (input valid, center_distance, left_distance, right_distance,
                    output ready);
endinterface

/* hdl/wfs_drive_if.sv */
`timescale 1ns / 1ps

interface wfs_drive_if import wfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        drive_mode;
    logic [DUTY_W-1:0] left_speed;
    logic [DUTY_W-1:0] right_speed;

    modport source (output valid, drive_mode, left_speed, right_speed, input ready);
    modport sink   (input valid, drive_mode, left_speed, right_speed, output ready);
endinterface

/* hdl/wfs_cfg_if.sv */
`timescale 1ns / 1ps

interface wfs_cfg_if import wfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/wall_follow_pd_steering.sv */
`timescale 1ns / 1ps

// Wall-following PD steering for a two-wheel differential drive.
//
// Channels (valid/ready, a transaction moves at a clock edge with both high):
//   sensor : center/left/right range readings in cm, 11-bit signed, -1 = no echo
//   drive  : drive_mode (0 steer, 1 evade left, 2 evade right) and two wheel duties
//   cfg    : register writes (index, data), always ready, taken at once.
//            0 cruise duty, 1 prop_gain, 2 deriv_gain, 3 front_threshold,
//            4 side_limit, 5 turn_speed; other indexes are dropped.
// Path: a reading goes into the input register, then through one pass of the PD
//   datapath into the output register. Throughput: one reading per clock while
//   drive.ready does not stall the output; the stored error is written together
//   with the output register, so the next reading sees it in time.
// Reset: registers return to their defaults (250, 4.0, 5.0, 7, 60, 200), the
//   stored error clears and both pipeline stages empty.
// Stall: while drive.ready is low the output register holds its command; the
//   input register still takes one more reading if it is empty, then sensor.ready drops.
module wall_follow_pd_steering
    import wfs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    wfs_sensor_if.sink   sensor,
    wfs_drive_if.source  drive,
    wfs_cfg_if.sink      cfg
);

    localparam int SIDE_W = LIMIT_W + 1;    // clamped side reading as signed
    localparam int E_W    = LIMIT_W + 1;    // left minus right
    localparam int D_W    = E_W + 1;        // error minus stored error
    localparam int SUM_W  = 21;             // kp*e + kd*d fits in 21 signed bits
    localparam int PD_W   = SUM_W - 4;      // after the Q4.4 shift
    localparam int SPD_W  = PD_W + 1;       // cruise duty +/- pd

    // ---------------- configuration registers ----------------
    logic [DUTY_W-1:0]  cruise_duty_reg;
    logic [GAIN_W-1:0]  prop_gain_reg;
    logic [GAIN_W-1:0]  deriv_gain_reg;
    logic [LIMIT_W-1:0] front_threshold_reg;
    logic [LIMIT_W-1:0] side_limit_reg;
    logic [DUTY_W-1:0]  turn_speed_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_duty_reg     <= RST_CRUISE_DUTY;
            prop_gain_reg       <= RST_PROP_GAIN;
            deriv_gain_reg      <= RST_DERIV_GAIN;
            front_threshold_reg <= RST_FRONT_THRESHOLD;
            side_limit_reg      <= RST_SIDE_LIMIT;
            turn_speed_reg      <= RST_TURN_SPEED;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_CRUISE_DUTY:     cruise_duty_reg     <= cfg.data[DUTY_W-1:0];
                REG_PROP_GAIN:       prop_gain_reg       <= cfg.data[GAIN_W-1:0];
                REG_DERIV_GAIN:      deriv_gain_reg      <= cfg.data[GAIN_W-1:0];
                REG_FRONT_THRESHOLD: front_threshold_reg <= cfg.data[LIMIT_W-1:0];
                REG_SIDE_LIMIT:      side_limit_reg      <= cfg.data[LIMIT_W-1:0];
                REG_TURN_SPEED:      turn_speed_reg      <= cfg.data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;      // input register moves into the output register

    assign advance      = !out_valid_reg || drive.ready;
    assign sensor.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sensor.ready)
                in_valid_reg <= sensor.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // ---------------- input register ----------------
    logic signed [DIST_W-1:0] center_reg;
    logic signed [DIST_W-1:0] left_reg;
    logic signed [DIST_W-1:0] right_reg;

    always_ff @(posedge clk)
    begin
        if (sensor.ready && sensor.valid)
        begin
            center_reg <= sensor.center_distance;
            left_reg   <= sensor.left_distance;
            right_reg  <= sensor.right_distance;
        end
    end

    // ---------------- steering datapath ----------------
    logic signed [ERR_W-1:0]  last_error_reg;
    logic signed [ERR_W-1:0]  last_error_next;

    logic                     evade;
    logic signed [SIDE_W-1:0] lim_s;
    logic signed [SIDE_W-1:0] left_side;
    logic signed [SIDE_W-1:0] right_side;
    logic signed [E_W-1:0]    err;
    logic signed [D_W-1:0]    derr;
    logic signed [SUM_W-1:0]  kp_term;
    logic signed [SUM_W-1:0]  kd_term;
    logic signed [SUM_W-1:0]  pd_sum;
    logic signed [SUM_W-1:0]  pd_adj;
    logic signed [PD_W-1:0]   pd;
    logic signed [SPD_W-1:0]  left_raw;
    logic signed [SPD_W-1:0]  right_raw;

    drive_mode_t              mode_next;
    logic [DUTY_W-1:0]        left_next;
    logic [DUTY_W-1:0]        right_next;

    // Side reading: no echo -> limit, other negatives -> 0, else clamp to limit.
    function automatic logic signed [SIDE_W-1:0] side_clamp(
        input logic signed [DIST_W-1:0] d,
        input logic signed [SIDE_W-1:0] lim
    );
        logic signed [SIDE_W-1:0] r;
        if (d == -DIST_W'(1))
            r = lim;
        else if (d < 0)
            r = '0;
        else if (SIDE_W'(d) > lim)
            r = lim;
        else
            r = SIDE_W'(d);
        return r;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_clamp(input logic signed [SPD_W-1:0] v);
        logic [DUTY_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > SPD_W'(255))
            r = '1;
        else
            r = v[DUTY_W-1:0];
        return r;
    endfunction

    always_comb
    begin
        evade = (center_reg > 0) &&
                (center_reg < $signed({1'b0, front_threshold_reg}));

        lim_s      = $signed({1'b0, side_limit_reg});
        left_side  = side_clamp(left_reg, lim_s);
        right_side = side_clamp(right_reg, lim_s);
        err        = left_side - right_side;
        derr       = D_W'(err) - D_W'(last_error_reg);

        kp_term = SUM_W'($signed({1'b0, prop_gain_reg})) * SUM_W'(err);
        kd_term = SUM_W'($signed({1'b0, deriv_gain_reg})) * SUM_W'(derr);
        pd_sum  = kp_term + kd_term;

        // divide by 16, rounding toward zero
        pd_adj = pd_sum + (pd_sum < 0 ? SUM_W'(15) : SUM_W'(0));
        pd     = pd_adj[SUM_W-1:4];

        left_raw  = SPD_W'($signed({1'b0, cruise_duty_reg})) - SPD_W'(pd);
        right_raw = SPD_W'($signed({1'b0, cruise_duty_reg})) + SPD_W'(pd);

        if (evade)
        begin
            mode_next       = (left_reg > right_reg) ? MODE_LEFT : MODE_RIGHT;
            left_next       = turn_speed_reg;
            right_next      = turn_speed_reg;
            last_error_next = '0;
        end
        else
        begin
            mode_next  = MODE_STEER;
            left_next  = duty_clamp(left_raw);
            right_next = duty_clamp(right_raw);
            if (err > E_W'(127))
                last_error_next = ERR_W'(127);
            else if (err < -E_W'(128))
                last_error_next = -ERR_W'(128);
            else
                last_error_next = err[ERR_W-1:0];
        end
    end

    // stored error follows each item as it enters the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_error_reg <= '0;
        else if (advance && in_valid_reg)
            last_error_reg <= last_error_next;
    end

    // ---------------- output register ----------------
    drive_mode_t       mode_reg;
    logic [DUTY_W-1:0] left_speed_reg;
    logic [DUTY_W-1:0] right_speed_reg;

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            mode_reg        <= mode_next;
            left_speed_reg  <= left_next;
            right_speed_reg <= right_next;
        end
    end

    assign drive.valid       = out_valid_reg;
    assign drive.drive_mode  = mode_reg;
    assign drive.left_speed  = left_speed_reg;
    assign drive.right_speed = right_speed_reg;

endmodule

/* tb/sv/wall_follow_pd_steering_tb.sv */
`timescale 1ns / 1ps

// Testbench for the wall-following PD steering block.
module wall_follow_pd_steering_tb;
    import wfs_pkg::*;

    // Half of the 8 ns clock period.
    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 11;
    // Two register stages from reading to command; a few spare cycles on top.
    localparam int PIPE_SLACK = 6;
    // Roughly 2000 readings at a few cycles each in the worst stall phases.
    // This limit leaves a wide margin over that.
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int NUM_PHASES = 8;

    // Indexes past the six registers.  The block must drop writes to these.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum int {
        KIND_DEFAULT,
        KIND_RANDOM,
        KIND_MAX,
        KIND_WIDE,
        KIND_ZERO,
        KIND_RAW
    } cfg_kind_t;

    typedef struct {
        drive_mode_t       mode;
        logic [DUTY_W-1:0] left;
        logic [DUTY_W-1:0] right;
    } drive_cmd_t;

    // Scoreboard.  It keeps its own copy of the registers and of the stored
    // error, and it computes the drive command for each accepted reading set.
    // Commands wait in order until the drive channel returns them.
    class steering_scoreboard;
        logic [DUTY_W-1:0]  cruise_duty;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [LIMIT_W-1:0] front_thr;
        logic [LIMIT_W-1:0] side_lim;
        logic [DUTY_W-1:0]  turn_speed;
        int                 prev_err;
        drive_cmd_t         cmd_q[$];
        int                 errors;

        function new();
            cruise_duty = RST_CRUISE_DUTY;
            prop_gain   = RST_PROP_GAIN;
            deriv_gain  = RST_DERIV_GAIN;
            front_thr   = RST_FRONT_THRESHOLD;
            side_lim    = RST_SIDE_LIMIT;
            turn_speed  = RST_TURN_SPEED;
            prev_err    = 0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CRUISE_DUTY:     cruise_duty = data[DUTY_W-1:0];
                REG_PROP_GAIN:       prop_gain   = data[GAIN_W-1:0];
                REG_DERIV_GAIN:      deriv_gain  = data[GAIN_W-1:0];
                REG_FRONT_THRESHOLD: front_thr   = data[LIMIT_W-1:0];
                REG_SIDE_LIMIT:      side_lim    = data[LIMIT_W-1:0];
                REG_TURN_SPEED:      turn_speed  = data[DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        // No echo reads as the limit; other negatives read as zero.
        function int clamp_side(int reading);
            if (reading == -1)
                return int'(side_lim);
            if (reading < 0)
                return 0;
            if (reading > int'(side_lim))
                return int'(side_lim);
            return reading;
        endfunction

        function logic [DUTY_W-1:0] clamp_duty(int v);
            if (v < 0)
                return '0;
            if (v > 255)
                return '1;
            return v[DUTY_W-1:0];
        endfunction

        function void note_reading(logic signed [DIST_W-1:0] c,
                                   logic signed [DIST_W-1:0] l,
                                   logic signed [DIST_W-1:0] r);
            int         ci;
            int         li;
            int         ri;
            int         err;
            int         sum;
            int         pd;
            drive_cmd_t cmd;
            ci = c;
            li = l;
            ri = r;
            if (ci > 0 && ci < int'(front_thr))
            begin
                // Evade: turn toward the larger raw reading, a tie goes right.
                cmd.mode  = (li > ri) ? MODE_LEFT : MODE_RIGHT;
                cmd.left  = turn_speed;
                cmd.right = turn_speed;
                prev_err  = 0;
            end
            else
            begin
                err = clamp_side(li) - clamp_side(ri);
                sum = int'(prop_gain) * err + int'(deriv_gain) * (err - prev_err);
                pd  = sum / 16;     // truncates toward zero
                if (err > 127)
                    prev_err = 127;
                else if (err < -128)
                    prev_err = -128;
                else
                    prev_err = err;
                cmd.mode  = MODE_STEER;
                cmd.left  = clamp_duty(int'(cruise_duty) - pd);
                cmd.right = clamp_duty(int'(cruise_duty) + pd);
            end
            cmd_q.push_back(cmd);
        endfunction

        function void check_command(logic [1:0] mode, logic [DUTY_W-1:0] ls,
                                    logic [DUTY_W-1:0] rs);
            drive_cmd_t want;
            if (cmd_q.size() == 0)
            begin
                $display("%0t: unexpected drive transaction mode=%0d left=%0d right=%0d",
                         $time, mode, ls, rs);
                errors++;
                return;
            end
            want = cmd_q.pop_front();
            if (mode !== want.mode)
            begin
                $display("%0t: drive_mode mismatch, expected %0d, actual %0d",
                         $time, want.mode, mode);
                errors++;
            end
            if (ls !== want.left)
            begin
                $display("%0t: left_speed mismatch, expected %0d, actual %0d",
                         $time, want.left, ls);
                errors++;
            end
            if (rs !== want.right)
            begin
                $display("%0t: right_speed mismatch, expected %0d, actual %0d",
                         $time, want.right, rs);
                errors++;
            end
        endfunction

        function int pending();
            return cmd_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    wfs_sensor_if sensor_ch ();
    wfs_drive_if  drive_ch ();
    wfs_cfg_if    cfg_ch ();

    wall_follow_pd_steering dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sensor (sensor_ch),
        .drive  (drive_ch),
        .cfg    (cfg_ch)
    );

    steering_scoreboard sb;

    // Per-phase idling: percent of cycles the sender sits out before a
    // transaction, and percent of cycles the receiver holds ready low.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // Watchdog.  A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver back-pressure, changed only at the falling edge.
    always @(negedge clk)
    begin
        drive_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every command that moves on the drive channel goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && drive_ch.valid && drive_ch.ready)
            sb.check_command(drive_ch.drive_mode, drive_ch.left_speed,
                             drive_ch.right_speed);
    end

    // One sensor transaction.  Random idle cycles go in front of it; valid
    // stays high straight into the next reading when there is no gap.
    task automatic send_reading(logic signed [DIST_W-1:0] c,
                                logic signed [DIST_W-1:0] l,
                                logic signed [DIST_W-1:0] r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            sensor_ch.valid = 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        sensor_ch.valid           = 1'b1;
        sensor_ch.center_distance = c;
        sensor_ch.left_distance   = l;
        sensor_ch.right_distance  = r;
        do
            @(posedge clk);
        while (!sensor_ch.ready);
        sb.note_reading(c, l, r);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.set_reg(idx, data);
    endtask

    // Stop sending, let every command come back, then give the pipeline a
    // few more cycles so nothing is in flight when registers change.
    task automatic wait_idle();
        @(negedge clk);
        sensor_ch.valid = 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    // Writes all six registers, plus the two spare indexes with junk data.
    task automatic configure(logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] kp,
                             logic [CFG_DATA_W-1:0] kd, logic [CFG_DATA_W-1:0] thr,
                             logic [CFG_DATA_W-1:0] lim, logic [CFG_DATA_W-1:0] turn);
        write_reg(REG_SPARE_6, CFG_DATA_W'($urandom_range(1023)));
        write_reg(REG_CRUISE_DUTY, base);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_FRONT_THRESHOLD, thr);
        write_reg(REG_SIDE_LIMIT, lim);
        write_reg(REG_TURN_SPEED, turn);
        write_reg(REG_SPARE_7, CFG_DATA_W'($urandom_range(1023)));
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic pick_config(cfg_kind_t kind);
        case (kind)
            KIND_DEFAULT:
                configure(CFG_DATA_W'(RST_CRUISE_DUTY), CFG_DATA_W'(RST_PROP_GAIN),
                          CFG_DATA_W'(RST_DERIV_GAIN), RST_FRONT_THRESHOLD,
                          RST_SIDE_LIMIT, CFG_DATA_W'(RST_TURN_SPEED));
            // Everything at the top of the field, 8-bit registers keep the low byte.
            KIND_MAX:
                configure('1, '1, '1, '1, '1, '1);
            KIND_ZERO:
                configure('0, '0, '0, '0, '0, '0);
            // Side limit past 127 so the stored error saturates.
            KIND_WIDE:
                configure(CFG_DATA_W'($urandom_range(255)),
                          CFG_DATA_W'($urandom_range(255)),
                          CFG_DATA_W'($urandom_range(255)),
                          CFG_DATA_W'($urandom_range(2, 517)),
                          CFG_DATA_W'($urandom_range(128, 517)),
                          CFG_DATA_W'($urandom_range(255)));
            KIND_RAW:
                configure(CFG_DATA_W'($urandom_range(1023)),
                          CFG_DATA_W'($urandom_range(1023)),
                          CFG_DATA_W'($urandom_range(1023)),
                          CFG_DATA_W'($urandom_range(1023)),
                          CFG_DATA_W'($urandom_range(1023)),
                          CFG_DATA_W'($urandom_range(1023)));
            default:
                configure(CFG_DATA_W'($urandom_range(255)),
                          CFG_DATA_W'($urandom_range(255)),
                          CFG_DATA_W'($urandom_range(255)),
                          CFG_DATA_W'($urandom_range(2, 40)),
                          CFG_DATA_W'($urandom_range(10, 127)),
                          CFG_DATA_W'($urandom_range(255)));
        endcase
    endtask

    // Center readings: inside the evade window or just at its edges,
    // plus no echo, zero, the plain working range and raw bit patterns.
    function automatic logic signed [DIST_W-1:0] rand_center();
        int pick;
        int thr;
        pick = $urandom_range(99);
        thr  = int'(sb.front_thr);
        if (pick < 25)
            return (thr >= 2) ? DIST_W'($urandom_range(1, thr - 1)) : '0;
        if (pick < 32)
            return DIST_W'(thr);
        if (pick < 37)
            return (thr >= 1) ? DIST_W'(thr - 1) : '0;
        if (pick < 47)
            return '1;
        if (pick < 52)
            return '0;
        if (pick < 62)
            return DIST_W'($urandom_range(2047));
        return DIST_W'($urandom_range(517));
    endfunction

    // Side readings: no echo, other negatives, values around the limit,
    // raw bit patterns, and ordinary distances up to the limit.
    function automatic logic signed [DIST_W-1:0] rand_side();
        int pick;
        int lim;
        int v;
        pick = $urandom_range(99);
        lim  = int'(sb.side_lim);
        if (pick < 12)
            return '1;
        if (pick < 17)
        begin
            v = -int'($urandom_range(1024, 2));
            return v[DIST_W-1:0];
        end
        if (pick < 30)
        begin
            v = lim + int'($urandom_range(2)) - 1;
            return DIST_W'((v < 0) ? 0 : v);
        end
        if (pick < 42)
            return DIST_W'($urandom_range(2047));
        return DIST_W'($urandom_range(lim));
    endfunction

    initial
    begin
        cfg_kind_t phase_kind[NUM_PHASES];
        int        phase_send[NUM_PHASES];
        int        phase_recv[NUM_PHASES];
        int        p;
        int        n;

        phase_kind = '{KIND_DEFAULT, KIND_RANDOM, KIND_MAX, KIND_WIDE,
                       KIND_ZERO, KIND_RANDOM, KIND_RAW, KIND_WIDE};
        phase_send = '{0, 62, 0, 14, 0, 62, 0, 14};
        phase_recv = '{0, 0, 62, 14, 0, 0, 62, 14};

        sb = new();

        // Inputs known from time zero; drive ready follows at the first falling edge.
        rst_n                     = 1'b0;
        sensor_ch.valid           = 1'b0;
        sensor_ch.center_distance = '0;
        sensor_ch.left_distance   = '0;
        sensor_ch.right_distance  = '0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.index              = '0;
        cfg_ch.data               = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed part at the reset register values (threshold 7, limit 60).
        send_reading(11'sd0, -11'sd1, -11'sd1);        // zero center, both no echo
        send_reading(11'sd1, 11'sd10, 11'sd5);         // lowest evading center, turn left
        send_reading(11'sd6, 11'sd5, 11'sd5);          // tie turns right
        send_reading(11'sd7, 11'sd100, 11'sd0);        // center at threshold steers
        send_reading(-11'sd1, 11'sd0, 11'sd60);        // no echo in front
        send_reading(-11'sd1024, -11'sd2, 11'sd30);    // other negatives
        send_reading(11'sd1023, 11'sd1023, -11'sd1024);
        send_reading(11'sd3, -11'sd1, 11'sd517);       // evade, raw compare: right
        send_reading(11'sd517, -11'sd1024, 11'sd1023);
        send_reading(-11'sd5, 11'sd60, 11'sd59);
        send_reading(11'sd2, 11'sd1023, -11'sd1);      // evade left, error cleared
        send_reading(11'sd100, 11'sd30, 11'sd30);
        send_reading(11'sd0, 11'sd0, 11'sd0);
        wait_idle();

        // Wide limit: the error runs past the 8-bit store and saturates.
        configure(10'd128, 10'd255, 10'd255, 10'd517, 10'd517, 10'd255);
        send_reading(11'sd516, 11'sd1, 11'sd0);        // evade at the top of the window
        send_reading(11'sd517, -11'sd1, 11'sd0);       // error 517, stored as 127
        send_reading(-11'sd1, 11'sd0, -11'sd1);        // error -517 against 127
        send_reading(-11'sd1, 11'sd300, 11'sd100);
        send_reading(-11'sd1, 11'sd200, 11'sd300);
        send_reading(11'sd0, 11'sd1000, 11'sd0);
        send_reading(-11'sd1, 11'sd5, 11'sd5);
        wait_idle();

        // All registers at zero: no evade window, limit zero.
        configure('0, '0, '0, '0, '0, '0);
        send_reading(11'sd1, 11'sd5, 11'sd3);
        send_reading(-11'sd1, -11'sd1, -11'sd1);
        wait_idle();

        // Random phases, each with its own registers and idling pattern.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            pick_config(phase_kind[p]);
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_reading(rand_center(), rand_side(), rand_side());
            wait_idle();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
hdl/wfs_pkg.sv
hdl/wfs_sensor_if.sv
hdl/wfs_drive_if.sv
hdl/wfs_cfg_if.sv
hdl/wall_follow_pd_steering.sv
tb/sv/wall_follow_pd_steering_tb.sv
